[design/fcgl_pkg.sv]
// Package for the cmap glyph index lookup core: types, codes and sizes.
// Used by font_cmap_glyph_index_lookup_core; depends on nothing.
package fcgl_pkg;

    localparam int unsigned DefMapSlots   = 32;
    localparam int unsigned DefListBytes  = 65536;
    // wide enough for any list address sum and for the list size itself
    localparam int unsigned AddrCalcW     = 25;

    localparam logic [1:0] OP_MAP_WRITE  = 2'd0;
    localparam logic [1:0] OP_BYTE_WRITE = 2'd1;
    localparam logic [1:0] OP_LOOKUP     = 2'd2;

    localparam logic [1:0] FMT_FULL_DENSE  = 2'd0;
    localparam logic [1:0] FMT_FULL_SPARSE = 2'd1;
    localparam logic [1:0] FMT_TINY_DENSE  = 2'd2;
    localparam logic [1:0] FMT_TINY_SPARSE = 2'd3;

    localparam logic REG_MAP_COUNT = 1'b0;

    typedef struct packed {
        logic [20:0] first_code;
        logic [15:0] span;
        logic [15:0] base;
        logic [15:0] cl_start;
        logic [15:0] ol_start;
        logic [15:0] cl_len;
        logic [1:0]  fmt;
    } t_map_entry;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MAP_W,
        S_MAP,
        S_DB_W,
        S_DB,
        S_PROBE,
        S_CL_LO_W,
        S_CL_LO,
        S_CL_HI_W,
        S_CL_HI,
        S_OF_LO_W,
        S_OF_LO,
        S_OF_HI_W,
        S_OF_HI,
        S_DONE
    } t_state;

endpackage

[design/font_cmap_glyph_index_lookup_core.sv]
// Cmap glyph index lookup core: map table memory, list byte memory, scan sequencer.
// Depends on fcgl_pkg.
//
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_ready  | i_operation .. i_lookup_code
// output  | out       | o_valid / i_ready  | o_glyph_index, o_glyph_found
// config  | in        | APB psel/penable   | map_count at address 0
//
// A lookup visits maps in slot order, binary-searches the code list of a sparse
// map, then makes the final reads of a dense byte or an offset half and ends in
// the done state; each step waits on a memory read.
// Reset (synchronous, i_rst_n low) clears map_count and control state only.
// o_ready is high only while idle; a result waiting on i_ready holds the next lookup in the done state.
module font_cmap_glyph_index_lookup_core #(
    parameter int unsigned MAP_SLOTS         = fcgl_pkg::DefMapSlots,
    parameter int unsigned LIST_MEMORY_BYTES = fcgl_pkg::DefListBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [4:0]  i_map_slot,
    input  logic [20:0] i_first_code,
    input  logic [15:0] i_code_span,
    input  logic [15:0] i_base_glyph,
    input  logic [15:0] i_code_list_start,
    input  logic [15:0] i_offset_list_start,
    input  logic [15:0] i_code_list_length,
    input  logic [1:0]  i_map_format,
    input  logic [15:0] i_byte_address,
    input  logic [7:0]  i_byte_value,
    input  logic [20:0] i_lookup_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [16:0] o_glyph_index,
    output logic        o_glyph_found,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fcgl_pkg::*;

    localparam int unsigned SW = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
    localparam int unsigned AW = $clog2(LIST_MEMORY_BYTES);
    localparam logic [AddrCalcW-1:0] LMB = AddrCalcW'(LIST_MEMORY_BYTES);
    localparam logic [8:0] NSLOTS = 9'(MAP_SLOTS);

    t_map_entry map_mem [MAP_SLOTS];
    logic [7:0] list_mem [LIST_MEMORY_BYTES];

    t_state             r_state, n_state;
    logic [5:0]         r_map_count;
    logic [20:0]        r_code, n_code;
    logic [SW-1:0]      r_slot, n_slot;
    logic [AW-1:0]      r_laddr, n_laddr;
    logic signed [17:0] r_lo, n_lo, r_hi, n_hi;
    logic [15:0]        r_mid, n_mid;
    logic [7:0]         r_lo_byte, n_lo_byte;
    logic [16:0]        r_result, n_result;
    logic               r_out_valid, n_out_valid;
    logic [16:0]        r_glyph, n_glyph;
    t_map_entry         r_map_q;
    logic [7:0]         r_list_q;

    // combinational helpers
    logic               in_acc, cfg_wr;
    logic [8:0]         n_eff, slot_next;
    logic [21:0]        range_end;
    logic               hit;
    logic [15:0]        rel, half_v;
    logic [AddrCalcW-1:0] a_dense, a_probe, a_off;
    logic signed [17:0] mid_w, lo_up, hi_dn;

    assign in_acc = i_valid && o_ready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAP_COUNT) ? {26'd0, r_map_count} : 32'd0;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_glyph_index = r_glyph;
    assign o_glyph_found = (r_glyph != 17'd0);

    // memories: written only while idle, read every cycle
    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == OP_MAP_WRITE && {4'd0, i_map_slot} < NSLOTS) begin
            map_mem[SW'({4'd0, i_map_slot})] <= '{i_first_code, i_code_span, i_base_glyph,
                i_code_list_start, i_offset_list_start, i_code_list_length, i_map_format};
        end
        r_map_q <= map_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == OP_BYTE_WRITE
                && AddrCalcW'(i_byte_address) < LMB) begin
            list_mem[AW'(i_byte_address)] <= i_byte_value;
        end
        r_list_q <= list_mem[r_laddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cfg_wr && paddr[2] == REG_MAP_COUNT) begin
                r_map_count <= pwdata[5:0];
            end
        end
        r_code    <= n_code;
        r_slot    <= n_slot;
        r_laddr   <= n_laddr;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_lo_byte <= n_lo_byte;
        r_result  <= n_result;
        r_glyph   <= n_glyph;
    end

    always_comb begin
        n_eff     = ({3'd0, r_map_count} > NSLOTS) ? NSLOTS : {3'd0, r_map_count};
        slot_next = 9'(r_slot) + 9'd1;
        range_end = {1'b0, r_map_q.first_code} + 22'(r_map_q.span);
        hit       = (r_code >= r_map_q.first_code) && ({1'b0, r_code} < range_end);
        rel       = 16'(r_code - r_map_q.first_code);
        a_dense   = AddrCalcW'(r_map_q.ol_start) + AddrCalcW'(rel);
        mid_w     = (r_lo + r_hi) >>> 1;
        a_probe   = AddrCalcW'(r_map_q.cl_start) + AddrCalcW'({mid_w[15:0], 1'b0});
        a_off     = AddrCalcW'(r_map_q.ol_start) + AddrCalcW'({r_mid, 1'b0});
        half_v    = {r_list_q, r_lo_byte};
        lo_up     = 18'(r_mid) + 18'sd1;
        hi_dn     = 18'(r_mid) - 18'sd1;

        n_state     = r_state;
        n_code      = r_code;
        n_slot      = r_slot;
        n_laddr     = r_laddr;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_lo_byte   = r_lo_byte;
        n_result    = r_result;
        n_out_valid = r_out_valid && !i_ready;
        n_glyph     = r_glyph;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_operation == OP_LOOKUP) begin
                    n_code = i_lookup_code;
                    n_slot = '0;
                    if (n_eff == 9'd0) begin
                        n_result = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_MAP_W;
                    end
                end
            end
            S_MAP_W: n_state = S_MAP;
            S_MAP: begin
                if (!hit) begin
                    if (slot_next >= n_eff) begin
                        n_result = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_slot  = SW'(slot_next);
                        n_state = S_MAP_W;
                    end
                end else begin
                    case (r_map_q.fmt)
                        FMT_TINY_DENSE: begin
                            n_result = 17'(r_map_q.base) + 17'(rel);
                            n_state  = S_DONE;
                        end
                        FMT_FULL_DENSE: begin
                            if (a_dense >= LMB) begin
                                n_result = '0;
                                n_state  = S_DONE;
                            end else begin
                                n_laddr = AW'(a_dense);
                                n_state = S_DB_W;
                            end
                        end
                        default: begin
                            n_lo    = '0;
                            n_hi    = 18'(r_map_q.cl_len) - 18'sd1;
                            n_state = S_PROBE;
                            if (r_map_q.cl_len == 16'd0) begin
                                if (slot_next >= n_eff) begin
                                    n_result = '0;
                                    n_state  = S_DONE;
                                end else begin
                                    n_slot  = SW'(slot_next);
                                    n_state = S_MAP_W;
                                end
                            end
                        end
                    endcase
                end
            end
            S_DB_W: n_state = S_DB;
            S_DB: begin
                n_result = 17'(r_map_q.base) + 17'(r_list_q);
                n_state  = S_DONE;
            end
            S_PROBE: begin
                n_mid = mid_w[15:0];
                if (a_probe >= LMB - AddrCalcW'(1)) begin
                    // code list runs off memory: sparse miss
                    if (slot_next >= n_eff) begin
                        n_result = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_slot  = SW'(slot_next);
                        n_state = S_MAP_W;
                    end
                end else begin
                    n_laddr = AW'(a_probe);
                    n_state = S_CL_LO_W;
                end
            end
            S_CL_LO_W: n_state = S_CL_LO;
            S_CL_LO: begin
                n_lo_byte = r_list_q;
                n_laddr   = r_laddr + AW'(1);
                n_state   = S_CL_HI_W;
            end
            S_CL_HI_W: n_state = S_CL_HI;
            S_CL_HI: begin
                if (half_v == rel) begin
                    if (r_map_q.fmt == FMT_TINY_SPARSE) begin
                        n_result = 17'(r_map_q.base) + 17'(r_mid);
                        n_state  = S_DONE;
                    end else if (a_off >= LMB - AddrCalcW'(1)) begin
                        n_result = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_laddr = AW'(a_off);
                        n_state = S_OF_LO_W;
                    end
                end else begin
                    if (half_v < rel) begin
                        n_lo = lo_up;
                    end else begin
                        n_hi = hi_dn;
                    end
                    if (n_lo > n_hi) begin
                        if (slot_next >= n_eff) begin
                            n_result = '0;
                            n_state  = S_DONE;
                        end else begin
                            n_slot  = SW'(slot_next);
                            n_state = S_MAP_W;
                        end
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_OF_LO_W: n_state = S_OF_LO;
            S_OF_LO: begin
                n_lo_byte = r_list_q;
                n_laddr   = r_laddr + AW'(1);
                n_state   = S_OF_HI_W;
            end
            S_OF_HI_W: n_state = S_OF_HI;
            S_OF_HI: begin
                n_result = 17'(r_map_q.base) + 17'(half_v);
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_glyph     = r_result;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done state");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP) |-> (9'(r_slot) < n_eff))
        else $error("map slot beyond active count");

    a_probe_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_lo >= 0 && r_lo <= r_hi))
        else $error("binary search bounds crossed");

    a_hold_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_DONE) |=> !$rose(o_valid))
        else $error("result left early during search");

endmodule
